// ===== rtl/core/hhve_pkg.sv =====
// Shared types and constants for the header value sanitizer.
package hhve_pkg;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_OK       = 2'd1;
    localparam logic [1:0] KIND_ILLEGAL  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [1:0] FAULT_NONE = 2'd0;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_NBSP  = 8'hA0;
    localparam logic [7:0] CHAR_TOP   = 8'hFF;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  out_kind;
        logic [15:0] out_length;
        logic        out_last;
    } out_beat_t;

    typedef struct packed {
        logic load_in;
        logic pick_lead;
        logic pick_byte;
        logic set_lead;
        logic eval;
        logic emit_blank;
        logic emit_point;
        logic emit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic fault_none;
        logic lead_pending;
        logic byte_hi;
        logic in_last;
        logic used;
        logic ev_emit;
        logic blanks_none;
        logic blanks_one;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/http_header_value_encoder_top.sv =====
// Top level of the header value sanitizer: controller plus datapath.
// Each input beat passes through intake, lead check, byte check and finish steps, plus an evaluate
// step per character evaluated, a send step per character sent and a flush step per held blank;
// a stalled m_ready holds the flush and send steps and the finish step of a value's last beat.
// A result beat is registered at its flush, send or finish step and waits in the output register.
// Reset (aresetn low, synchronous) clears all per-value state and drops any pending result.
module http_header_value_encoder_top #(
    parameter int              BLANK_DEPTH = 32,
    parameter longint unsigned LENGTH_MAX  = 65535
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hhve_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hhve_pkg::out_beat_t m_data
);
    import hhve_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    hhve_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hhve_dp #(
        .BLANK_DEPTH (BLANK_DEPTH),
        .LENGTH_MAX  (LENGTH_MAX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/hhve_dp.sv =====
// Datapath: input latch, lead byte, blank store, counters and result register.
module hhve_dp #(
    parameter int              BLANK_DEPTH = 32,
    parameter longint unsigned LENGTH_MAX  = 65535
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hhve_pkg::in_beat_t  s_data,
    input  hhve_pkg::dp_cmd_t   cmd,
    output hhve_pkg::dp_sts_t   sts,
    input  logic                m_ready,
    output logic                m_valid,
    output hhve_pkg::out_beat_t m_data
);
    import hhve_pkg::*;

    localparam int CW = $clog2(BLANK_DEPTH + 1);
    localparam logic [15:0] LEN_CAP =
        (LENGTH_MAX < 64'd65535) ? 16'(LENGTH_MAX) : 16'hFFFF;

    logic [7:0]             in_byte_reg, in_byte_next;
    logic                   in_last_reg, in_last_next;
    logic                   used_reg, used_next;
    logic [10:0]            point_reg, point_next;
    logic                   seen_reg, seen_next;
    logic                   lead_pending_reg, lead_pending_next;
    logic [7:0]             lead_value_reg, lead_value_next;
    logic [CW-1:0]          blank_count_reg, blank_count_next;
    logic [BLANK_DEPTH-1:0] blank_tab_reg, blank_tab_next;
    logic [15:0]            kept_reg, kept_next;
    logic [1:0]             fault_reg, fault_next;
    logic                   m_valid_reg, m_valid_next;
    out_beat_t              m_data_reg, m_data_next;

    logic        byte_cont;
    logic [10:0] pair_point;
    logic        pt_blank, pt_pass, out_free;
    logic [15:0] kept_inc;

    assign byte_cont  = (in_byte_reg[7:6] == 2'b10);
    assign pair_point = (lead_value_reg[7:5] == 3'b110) ?
                        {lead_value_reg[4:0], in_byte_reg[5:0]} : 11'd0;
    assign pt_blank   = (point_reg == {3'b000, CHAR_SPACE}) ||
                        (point_reg == {3'b000, CHAR_TAB});
    assign pt_pass    = ((point_reg >= {3'b000, CHAR_SPACE}) &&
                         (point_reg <= {3'b000, CHAR_TILDE})) ||
                        ((point_reg >= {3'b000, CHAR_NBSP}) &&
                         (point_reg <= {3'b000, CHAR_TOP}));
    assign out_free   = !m_valid_reg || m_ready;
    assign kept_inc   = (kept_reg < LEN_CAP) ? kept_reg + 16'd1 : kept_reg;

    always_comb begin
        in_byte_next      = in_byte_reg;
        in_last_next      = in_last_reg;
        used_next         = used_reg;
        point_next        = point_reg;
        seen_next         = seen_reg;
        lead_pending_next = lead_pending_reg;
        lead_value_next   = lead_value_reg;
        blank_count_next  = blank_count_reg;
        blank_tab_next    = blank_tab_reg;
        kept_next         = kept_reg;
        fault_next        = fault_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cmd.load_in) begin
            in_byte_next = s_data.in_byte;
            in_last_next = s_data.in_last;
            used_next    = 1'b0;
        end
        if (cmd.pick_lead) begin
            lead_pending_next = 1'b0;
            used_next         = byte_cont;
            point_next        = byte_cont ? pair_point : {3'b000, lead_value_reg};
        end
        if (cmd.pick_byte) begin
            point_next = {3'b000, in_byte_reg};
        end
        if (cmd.set_lead) begin
            lead_pending_next = 1'b1;
            lead_value_next   = in_byte_reg;
        end
        if (cmd.eval && (fault_reg == FAULT_NONE)) begin
            if (!pt_blank) begin
                seen_next = 1'b1;
                if (!pt_pass) begin
                    fault_next = KIND_ILLEGAL;
                end
            end else if (seen_reg) begin
                if (blank_count_reg == CW'(BLANK_DEPTH)) begin
                    fault_next = KIND_OVERFLOW;
                end else begin
                    for (int i = 0; i < BLANK_DEPTH; i++) begin
                        if (blank_count_reg == CW'(i)) begin
                            blank_tab_next[i] = (point_reg[7:0] == CHAR_TAB);
                        end
                    end
                    blank_count_next = blank_count_reg + CW'(1);
                end
            end
        end
        if (cmd.emit_blank) begin
            m_valid_next            = 1'b1;
            m_data_next.out_byte    = blank_tab_reg[0] ? CHAR_TAB : CHAR_SPACE;
            m_data_next.out_kind    = KIND_DATA;
            m_data_next.out_length  = 16'd0;
            m_data_next.out_last    = 1'b0;
            blank_tab_next          = blank_tab_reg >> 1;
            blank_count_next        = blank_count_reg - CW'(1);
            kept_next               = kept_inc;
        end
        if (cmd.emit_point) begin
            m_valid_next            = 1'b1;
            m_data_next.out_byte    = point_reg[7:0];
            m_data_next.out_kind    = KIND_DATA;
            m_data_next.out_length  = 16'd0;
            m_data_next.out_last    = 1'b0;
            kept_next               = kept_inc;
        end
        if (cmd.emit_status) begin
            m_valid_next            = 1'b1;
            m_data_next.out_byte    = 8'd0;
            m_data_next.out_kind    = (fault_reg == FAULT_NONE) ? KIND_OK : fault_reg;
            m_data_next.out_length  = (fault_reg == FAULT_NONE) ? kept_reg : 16'd0;
            m_data_next.out_last    = 1'b1;
            seen_next               = 1'b0;
            lead_pending_next       = 1'b0;
            blank_count_next        = '0;
            blank_tab_next          = '0;
            kept_next               = 16'd0;
            fault_next              = FAULT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg         <= 1'b0;
            lead_pending_reg <= 1'b0;
            blank_count_reg  <= '0;
            blank_tab_reg    <= '0;
            kept_reg         <= 16'd0;
            fault_reg        <= FAULT_NONE;
            m_valid_reg      <= 1'b0;
            used_reg         <= 1'b0;
        end else begin
            seen_reg         <= seen_next;
            lead_pending_reg <= lead_pending_next;
            blank_count_reg  <= blank_count_next;
            blank_tab_reg    <= blank_tab_next;
            kept_reg         <= kept_next;
            fault_reg        <= fault_next;
            m_valid_reg      <= m_valid_next;
            used_reg         <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        in_last_reg    <= in_last_next;
        point_reg      <= point_next;
        lead_value_reg <= lead_value_next;
        m_data_reg     <= m_data_next;
    end

    assign sts.fault_none   = (fault_reg == FAULT_NONE);
    assign sts.lead_pending = lead_pending_reg;
    assign sts.byte_hi      = (in_byte_reg >= LEAD_MIN);
    assign sts.in_last      = in_last_reg;
    assign sts.used         = used_reg;
    assign sts.ev_emit      = (fault_reg == FAULT_NONE) && !pt_blank && pt_pass;
    assign sts.blanks_none  = (blank_count_reg == '0);
    assign sts.blanks_one   = (blank_count_reg == CW'(1));
    assign sts.out_free     = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/hhve_ctrl.sv =====
// Controller state machine that sequences one input beat through the datapath.
module hhve_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hhve_pkg::dp_sts_t sts,
    output hhve_pkg::dp_cmd_t cmd
);
    import hhve_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LEAD   = 7'b0000010,
        ST_BYTE   = 7'b0000100,
        ST_EVAL   = 7'b0001000,
        ST_FLUSH  = 7'b0010000,
        ST_SEND   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   after_byte_reg, after_byte_next;
    state_t ret_state;

    assign ret_state = after_byte_reg ? ST_FINISH : ST_BYTE;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        after_byte_next = after_byte_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in     = 1'b1;
                    after_byte_next = 1'b0;
                    state_next      = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (sts.fault_none && sts.lead_pending) begin
                    cmd.pick_lead = 1'b1;
                    state_next    = ST_EVAL;
                end else begin
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE: begin
                after_byte_next = 1'b1;
                if (!sts.used && sts.fault_none) begin
                    if (sts.byte_hi && !sts.in_last) begin
                        cmd.set_lead = 1'b1;
                        state_next   = ST_FINISH;
                    end else begin
                        cmd.pick_byte = 1'b1;
                        state_next    = ST_EVAL;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.ev_emit) begin
                    state_next = sts.blanks_none ? ST_SEND : ST_FLUSH;
                end else begin
                    state_next = ret_state;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.emit_blank = 1'b1;
                    if (sts.blanks_one) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                if (sts.out_free) begin
                    cmd.emit_point = 1'b1;
                    state_next     = ret_state;
                end
            end
            ST_FINISH: begin
                if (!sts.in_last) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            after_byte_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            after_byte_reg <= after_byte_next;
        end
    end

endmodule

// ===== tb/tb_http_header_value_encoder_top.sv =====
// Self-checking testbench for the header value sanitizer: random and directed values, scoreboard.
`timescale 1ns / 1ps

module tb_http_header_value_encoder_top;
    import hhve_pkg::*;

    localparam int BLANK_DEPTH = 32;
    localparam longint unsigned LENGTH_MAX = 65535;
    localparam int HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;

    http_header_value_encoder_top #(
        .BLANK_DEPTH(BLANK_DEPTH),
        .LENGTH_MAX (LENGTH_MAX)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    in_beat_t  raw_q [$];
    out_beat_t sanitized_q [$];
    int        raw_count = 0;
    int        mismatches = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_ticket = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    logic      in_fire = 1'b0;

    // sanitizer state mirrored from the spec
    bit          seen_text;
    bit          lead_wait;
    logic [7:0]  lead_byte;
    int unsigned blank_n;
    logic [63:0] blank_tab;
    logic [15:0] kept_n;
    logic [1:0]  fault;

    function automatic void clear_value();
        seen_text = 1'b0;
        lead_wait = 1'b0;
        lead_byte = '0;
        blank_n   = 0;
        blank_tab = '0;
        kept_n    = '0;
        fault     = FAULT_NONE;
    endfunction

    function automatic void send_latin1(logic [7:0] b);
        out_beat_t o;
        o.out_byte   = b;
        o.out_kind   = KIND_DATA;
        o.out_length = '0;
        o.out_last   = 1'b0;
        sanitized_q.push_back(o);
        if (kept_n != 16'hFFFF && 64'(kept_n) < LENGTH_MAX) kept_n++;
    endfunction

    function automatic void absorb_char(logic [10:0] x);
        bit blank;
        int unsigned i;
        blank = (x == {3'b000, CHAR_SPACE}) || (x == {3'b000, CHAR_TAB});
        if (fault != FAULT_NONE) return;
        if (!seen_text) begin
            if (blank) return;
            seen_text = 1'b1;
        end
        if (blank) begin
            if (blank_n < BLANK_DEPTH) begin
                if (x == {3'b000, CHAR_TAB}) blank_tab[blank_n] = 1'b1;
                blank_n++;
            end else begin
                fault = KIND_OVERFLOW;
            end
            return;
        end
        if ((x >= {3'b000, CHAR_SPACE} && x <= {3'b000, CHAR_TILDE}) ||
            (x >= {3'b000, CHAR_NBSP} && x <= {3'b000, CHAR_TOP})) begin
            for (i = 0; i < blank_n; i++) send_latin1(blank_tab[i] ? CHAR_TAB : CHAR_SPACE);
            blank_n   = 0;
            blank_tab = '0;
            send_latin1(x[7:0]);
        end else begin
            fault = KIND_ILLEGAL;
        end
    endfunction

    function automatic void sanitize_beat(in_beat_t d);
        logic [7:0]  b;
        logic [10:0] x;
        bit          used;
        out_beat_t   st;
        b    = d.in_byte;
        used = 1'b0;
        if (fault == FAULT_NONE && lead_wait) begin
            lead_wait = 1'b0;
            if (b[7:6] == 2'b10) begin
                x = '0;
                if (lead_byte[7:5] == 3'b110) x = {lead_byte[4:0], b[5:0]};
                absorb_char(x);
                used = 1'b1;
            end else begin
                absorb_char({3'b000, lead_byte});
            end
        end
        if (!used && fault == FAULT_NONE) begin
            if (b >= LEAD_MIN && !d.in_last) begin
                lead_wait = 1'b1;
                lead_byte = b;
            end else begin
                absorb_char({3'b000, b});
            end
        end
        if (d.in_last) begin
            st.out_byte   = '0;
            st.out_kind   = (fault != FAULT_NONE) ? fault : KIND_OK;
            st.out_length = (fault != FAULT_NONE) ? 16'd0 : kept_n;
            st.out_last   = 1'b1;
            sanitized_q.push_back(st);
            clear_value();
        end
    endfunction

    initial clear_value();

    // scoreboard and predictor, sampled at the rising edge
    always @(posedge aclk) begin
        out_beat_t e;
        in_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) sanitize_beat(s_data);
            if (m_valid && m_ready) begin
                if (sanitized_q.size() == 0) begin
                    $error("unexpected result beat: byte %0h kind %0d length %0d last %0b",
                           m_data.out_byte, m_data.out_kind, m_data.out_length,
                           m_data.out_last);
                    mismatches++;
                end else begin
                    e = sanitized_q.pop_front();
                    if (m_data.out_byte !== e.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", e.out_byte, m_data.out_byte);
                        mismatches++;
                    end
                    if (m_data.out_kind !== e.out_kind) begin
                        $error("out_kind: expected %0d, got %0d", e.out_kind, m_data.out_kind);
                        mismatches++;
                    end
                    if (m_data.out_length !== e.out_length) begin
                        $error("out_length: expected %0d, got %0d",
                               e.out_length, m_data.out_length);
                        mismatches++;
                    end
                    if (m_data.out_last !== e.out_last) begin
                        $error("out_last: expected %0b, got %0b", e.out_last, m_data.out_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // input driver: advance on acceptance, idle at random
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (raw_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_data  <= raw_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void add_raw(logic [7:0] b, logic last);
        in_beat_t d;
        d.in_byte = b;
        d.in_last = last;
        raw_q.push_back(d);
        raw_count++;
    endfunction

    function automatic void add_value();
        logic [7:0] body [$];
        int n, k, j, sel, run;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) body.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(9) < 3) begin
                run = $urandom_range(3);
                for (j = 0; j < run; j++) body.push_back($urandom_range(1) ? CHAR_TAB : CHAR_SPACE);
            end
            n = $urandom_range(8, 1);
            for (k = 0; k < n; k++) begin
                sel = $urandom_range(99);
                if (sel < 40) begin
                    body.push_back(8'($urandom_range(8'h7E, 8'h21)));
                end else if (sel < 55) begin
                    body.push_back(8'($urandom_range(8'hFF, 8'hA0)));
                end else if (sel < 70) begin
                    if ($urandom_range(3) != 0) body.push_back(8'($urandom_range(8'hC3, 8'hC2)));
                    else body.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                    body.push_back(8'($urandom_range(8'hBF, 8'h80)));
                end else if (sel < 85) begin
                    run = ($urandom_range(7) == 0) ? $urandom_range(BLANK_DEPTH + 2, BLANK_DEPTH - 2)
                                                   : $urandom_range(4, 1);
                    for (j = 0; j < run; j++) body.push_back($urandom_range(1) ? CHAR_TAB : CHAR_SPACE);
                end else if (sel < 90) begin
                    body.push_back(8'($urandom_range(8'hFF, 8'hE0)));
                    body.push_back(8'($urandom_range(8'hBF, 8'h80)));
                end else if (sel < 95) begin
                    if ($urandom_range(1)) body.push_back(8'($urandom_range(8'h1F, 8'h00)));
                    else body.push_back(8'($urandom_range(8'h9F, 8'h7F)));
                end else begin
                    body.push_back(8'($urandom_range(255)));
                end
            end
        end
        for (k = 0; k < body.size(); k++) add_raw(body[k], k == body.size() - 1);
    endfunction

    task automatic wait_drained();
        @(posedge aclk);
        wait (raw_q.size() == 0 && !s_valid && sanitized_q.size() == 0);
        @(posedge aclk);
    endtask

    task automatic run_phase(int idle, int stall, int beats);
        int goal;
        idle_pct  = idle;
        stall_pct = stall;
        goal = raw_count + beats;
        while (raw_count < goal) add_value();
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct  = 20;
        stall_pct = 20;
        // leading blanks dropped, inner blanks flushed, trailing blanks dropped
        add_raw(CHAR_SPACE, 0); add_raw(CHAR_TAB, 0); add_raw(8'h41, 0);
        add_raw(CHAR_SPACE, 0); add_raw(CHAR_TAB, 0); add_raw(CHAR_NBSP, 0);
        add_raw(CHAR_SPACE, 0); add_raw(CHAR_TAB, 1);
        // overlong pairs that decode to space and tab
        add_raw(LEAD_MIN, 0); add_raw(8'hA0, 0); add_raw(8'h41, 0);
        add_raw(LEAD_MIN, 0); add_raw(8'h89, 0); add_raw(CHAR_TILDE, 1);
        // good pair, then a three-byte lead with continuation
        add_raw(8'hC3, 0); add_raw(8'hA9, 0); add_raw(8'hE0, 0); add_raw(8'h80, 1);
        // lead on the last byte stays Latin-1
        add_raw(CHAR_TOP, 1);
        // lone lead before ASCII, then a zero byte
        add_raw(8'hC5, 0); add_raw(8'h41, 0); add_raw(8'h00, 1);
        // DEL is rejected, rest swallowed
        add_raw(8'h7F, 0); add_raw(8'h41, 1);
        // blank-only value
        add_raw(CHAR_SPACE, 1);
        wait_drained();

        run_phase(0, 0, 50);
        run_phase(65, 0, 50);
        run_phase(0, 65, 50);
        run_phase(16, 16, 50);

        // hold the receiver off while the sender keeps offering
        idle_pct  = 0;
        stall_pct = 0;
        hold_ticket++;
        while (raw_count < 260) add_value();
        wait_drained();

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && sanitized_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
